// File: rtl/txcs_pkg.sv
// ============================================================================
// txcs_pkg
// Shared constants, opcodes and types of the toy core step block.
// ============================================================================
package txcs_pkg;

    localparam int STACK_BYTES_DEF = 1024;
    localparam int REG_COUNT       = 17;
    localparam int SP_REG          = 6;
    localparam int FLAG_REG        = 16;

    localparam int F_CF = 0;
    localparam int F_ZF = 6;
    localparam int F_SF = 7;
    localparam int F_OF = 11;

    localparam logic [4:0] OP_SUBI  = 5'd0;
    localparam logic [4:0] OP_ADD   = 5'd1;
    localparam logic [4:0] OP_ADDI  = 5'd2;
    localparam logic [4:0] OP_MUL   = 5'd3;
    localparam logic [4:0] OP_SHR   = 5'd4;
    localparam logic [4:0] OP_MOV   = 5'd5;
    localparam logic [4:0] OP_LOAD  = 5'd6;
    localparam logic [4:0] OP_STORE = 5'd7;
    localparam logic [4:0] OP_LDI   = 5'd8;
    localparam logic [4:0] OP_CMP   = 5'd9;
    localparam logic [4:0] OP_JE    = 5'd10;
    localparam logic [4:0] OP_JL    = 5'd11;
    localparam logic [4:0] OP_JLE   = 5'd12;
    localparam logic [4:0] OP_JGE   = 5'd13;
    localparam logic [4:0] OP_JBE   = 5'd14;
    localparam logic [4:0] OP_JMP   = 5'd15;
    localparam logic [4:0] OP_CALL  = 5'd16;
    localparam logic [4:0] OP_RET   = 5'd17;
    localparam logic [4:0] OP_PUSH  = 5'd18;
    localparam logic [4:0] OP_POP   = 5'd19;
    localparam logic [4:0] OP_PRINT = 5'd20;
    localparam logic [4:0] OP_READ  = 5'd21;

    // Request to the stack memory; the address is already range checked.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [31:0] wdata;
    } txcs_mreq_t;

endpackage

// File: rtl/txcs_ifs.sv
// ============================================================================
// txcs_ifs
// Valid/ready channels of the toy core step block.
// ============================================================================
interface txcs_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic signed [31:0] read_value;
    modport source (output valid, instr_word, read_value, input ready);
    modport sink   (input valid, instr_word, read_value, output ready);
endinterface

interface txcs_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        print_valid;
    logic signed [31:0] print_value;
    logic        halted;
    logic        done_res;
    logic        fault;
    modport source (output valid, next_pc, print_valid, print_value, halted, done_res,
                    fault, input ready);
    modport sink   (input valid, next_pc, print_valid, print_value, halted, done_res,
                    fault, output ready);
endinterface

interface txcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] program_words;
    modport source (output valid, program_words, input ready);
    modport sink   (input valid, program_words, output ready);
endinterface

// File: rtl/txcs_stack_mem.sv
// ============================================================================
// txcs_stack_mem
// Byte-addressed little-endian stack in four byte banks, unaligned words.
// ============================================================================
module txcs_stack_mem
    import txcs_pkg::*;
#(
    parameter int STACK_BYTES = STACK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  txcs_mreq_t  req,
    output logic [31:0] rdata,
    output logic        busy
);
    localparam int ROWS = STACK_BYTES / 4;
    localparam int AW   = $clog2(ROWS);

    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [1:0]    a0_reg;
    logic [7:0]    q_reg [4];

    assign busy = clr_busy_reg;

    // After reset every row is zeroed, one row per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            a0_reg <= req.addr[1:0];
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [7:0]    bank_mem [ROWS];
        logic [AW-1:0] row;
        logic [1:0]    j;

        // Bank k holds the byte whose address has low bits k.
        assign row = req.addr[AW+1:2] + AW'(2'(k) < req.addr[1:0]);
        assign j   = 2'(k) - req.addr[1:0];

        always_ff @(posedge clk)
        begin
            if (clr_busy_reg)
            begin
                bank_mem[clr_cnt_reg] <= 8'h00;
            end
            else if (req.wr)
            begin
                bank_mem[row] <= req.wdata[{j, 3'b000} +: 8];
            end
            if (req.rd)
            begin
                q_reg[k] <= bank_mem[row];
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            rdata[8*b +: 8] = q_reg[2'(a0_reg + 2'(b))];
        end
    end

endmodule

// File: rtl/toy_x86_like_core_step.sv
// ============================================================================
// toy_x86_like_core_step
// Executes one instruction word per item against a register file and stack.
// ============================================================================
// Channel  Dir  Payload
// cfg      in   program_words
// instr    in   instr_word, read_value
// result   out  next_pc, print_valid, print_value, halted, done_res, fault
//
// Load, pop and ret (ret when the stack is not empty) pass from execute to
// a memory stage, whose data comes from the stack's registered read port;
// other items finish in execute. The register file is read at the accept
// edge, with forwarding from the write of the same edge. After reset the
// stack is cleared row by row, taking no item until done. A stalled
// result register holds the item in execute or memory until it drains.
module toy_x86_like_core_step
    import txcs_pkg::*;
#(
    parameter int STACK_BYTES = STACK_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    txcs_cfg_if.sink      cfg,
    txcs_instr_if.sink    instr,
    txcs_result_if.source result
);
    typedef struct packed {
        logic [31:0] npc;
        logic        pv;
        logic [31:0] pval;
        logic        hl;
        logic        fault;
        logic        rw_en;
        logic [4:0]  rw_idx;
        logic [31:0] rw_val;
        logic        sp_en;
        logic [31:0] sp_val;
        logic        fl_en;
        logic [31:0] fl_val;
        logic        halt_set;
    } fin_t;

    localparam logic [31:0] SB  = 32'(STACK_BYTES);
    localparam logic [31:0] TOP = 32'(STACK_BYTES - 4);

    logic [15:0] prog_words_reg;
    logic [31:0] pc_reg, sp_reg, flags_reg;
    logic        halt_reg;
    logic        stage_e_reg, stage_m_reg;
    logic [4:0]  op_reg, r1_reg, r2_reg;
    logic [31:0] imm_reg, rv_reg;
    logic [31:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [31:0] q1_reg, q2_reg, q1_next, q2_next;

    logic        m_to_pc_reg, m_ok_reg, m_rw_en_reg, m_fault_reg;
    logic [4:0]  m_rw_idx_reg;
    logic [31:0] m_npc_reg, m_sp_reg;

    logic        out_valid_reg, out_pv_reg, out_hl_reg, out_done_reg, out_fault_reg;
    logic [31:0] out_npc_reg, out_pval_reg;

    txcs_mreq_t  mreq;
    logic [31:0] mrdata;
    logic        clr_busy;

    fin_t        e_fin, m_fin, fin;
    logic        e_need_mem, e_ld_pc, e_mok;
    logic [31:0] e_maddr;
    logic        out_free, fin_e, fin_m, adv_em, accept, fin_fire;
    logic        rf_we;
    logic [4:0]  ra1, ra2;
    logic [31:0] ld_data;

    txcs_stack_mem #(.STACK_BYTES(STACK_BYTES)) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (mrdata),
        .busy  (clr_busy)
    );

    assign cfg.ready = 1'b1;

    assign out_free = !out_valid_reg || result.ready;
    assign fin_e    = stage_e_reg && !e_need_mem && out_free;
    assign fin_m    = stage_m_reg && out_free;
    assign adv_em   = stage_e_reg && e_need_mem;
    assign fin_fire = fin_e || fin_m;
    assign instr.ready = !clr_busy && ((!stage_e_reg && !stage_m_reg) || fin_fire);
    assign accept   = instr.valid && instr.ready;

    // Execute: operands are in the read registers, sp and flags are live.
    always_comb
    begin
        logic [31:0] v1, v2, seq, tgt, d;
        logic        b1, b2, use1, use2, sfof;
        b1   = r1_reg >= 5'(REG_COUNT);
        b2   = r2_reg >= 5'(REG_COUNT);
        v1   = b1 ? 32'd0 : (r1_reg == 5'(SP_REG)) ? sp_reg :
               (r1_reg == 5'(FLAG_REG)) ? flags_reg : q1_reg;
        v2   = b2 ? 32'd0 : (r2_reg == 5'(SP_REG)) ? sp_reg :
               (r2_reg == 5'(FLAG_REG)) ? flags_reg : q2_reg;
        seq  = pc_reg + 32'd4;
        tgt  = seq + imm_reg;
        d    = v2 - v1;
        sfof = flags_reg[F_SF] ^ flags_reg[F_OF];
        use1 = 1'b0;
        use2 = 1'b0;
        e_fin = '0;
        e_fin.npc    = seq;
        e_fin.rw_idx = r1_reg;
        e_fin.sp_val = sp_reg;
        e_need_mem = 1'b0;
        e_ld_pc    = 1'b0;
        e_maddr    = sp_reg;
        mreq       = '0;

        if (halt_reg)
        begin
            e_fin.npc = pc_reg;
            e_fin.hl  = 1'b1;
        end
        else
        begin
            unique case (op_reg)
                OP_SUBI:
                begin
                    use1 = 1'b1; e_fin.rw_en = 1'b1; e_fin.rw_val = v1 - imm_reg;
                end
                OP_ADD:
                begin
                    use1 = 1'b1; use2 = 1'b1; e_fin.rw_en = 1'b1;
                    e_fin.rw_idx = r2_reg; e_fin.rw_val = v2 + v1;
                end
                OP_ADDI:
                begin
                    use1 = 1'b1; e_fin.rw_en = 1'b1; e_fin.rw_val = v1 + imm_reg;
                end
                OP_MUL:
                begin
                    use1 = 1'b1; use2 = 1'b1; e_fin.rw_en = 1'b1;
                    e_fin.rw_idx = r2_reg; e_fin.rw_val = v1 * v2;
                end
                OP_SHR:
                begin
                    use1 = 1'b1; e_fin.rw_en = 1'b1; e_fin.rw_val = v1 >> 1;
                end
                OP_MOV:
                begin
                    use1 = 1'b1; use2 = 1'b1; e_fin.rw_en = 1'b1;
                    e_fin.rw_idx = r2_reg; e_fin.rw_val = v1;
                end
                OP_LOAD:
                begin
                    use1 = 1'b1; use2 = 1'b1; e_fin.rw_en = 1'b1;
                    e_fin.rw_idx = r2_reg; e_maddr = v1 + imm_reg; e_need_mem = 1'b1;
                end
                OP_STORE:
                begin
                    use1 = 1'b1; use2 = 1'b1; e_maddr = v2 + imm_reg;
                    mreq.wr = 1'b1; mreq.wdata = v1;
                end
                OP_LDI:
                begin
                    use1 = 1'b1; e_fin.rw_en = 1'b1; e_fin.rw_val = imm_reg;
                end
                OP_CMP:
                begin
                    use1 = 1'b1; use2 = 1'b1; e_fin.fl_en = 1'b1;
                    e_fin.fl_val[F_ZF] = d == 32'd0;
                    e_fin.fl_val[F_SF] = d[31];
                    e_fin.fl_val[F_CF] = v2 < v1;
                    e_fin.fl_val[F_OF] = (v1[31] ^ v2[31]) && (d[31] ^ v2[31]);
                end
                OP_JE:  if (flags_reg[F_ZF]) e_fin.npc = tgt;
                OP_JL:  if (sfof) e_fin.npc = tgt;
                OP_JLE: if (sfof || flags_reg[F_ZF]) e_fin.npc = tgt;
                OP_JGE: if (!sfof) e_fin.npc = tgt;
                OP_JBE: if (flags_reg[F_ZF] || flags_reg[F_CF]) e_fin.npc = tgt;
                OP_JMP: e_fin.npc = tgt;
                OP_CALL:
                begin
                    e_maddr = sp_reg - 32'd4; e_fin.sp_en = 1'b1; e_fin.sp_val = e_maddr;
                    mreq.wr = 1'b1; mreq.wdata = seq; e_fin.npc = tgt;
                end
                OP_RET:
                begin
                    if (sp_reg == SB)
                    begin
                        e_fin.halt_set = 1'b1; e_fin.hl = 1'b1; e_fin.npc = pc_reg;
                    end
                    else
                    begin
                        e_need_mem = 1'b1; e_ld_pc = 1'b1;
                        e_fin.sp_en = 1'b1; e_fin.sp_val = sp_reg + 32'd4;
                    end
                end
                OP_PUSH:
                begin
                    use1 = 1'b1; e_maddr = sp_reg - 32'd4;
                    e_fin.sp_en = 1'b1; e_fin.sp_val = e_maddr;
                    mreq.wr = 1'b1; mreq.wdata = v1;
                end
                OP_POP:
                begin
                    use1 = 1'b1; e_fin.rw_en = 1'b1; e_need_mem = 1'b1;
                    e_fin.sp_en = 1'b1; e_fin.sp_val = sp_reg + 32'd4;
                end
                OP_PRINT:
                begin
                    use1 = 1'b1; e_fin.pv = 1'b1; e_fin.pval = v1;
                end
                OP_READ:
                begin
                    use1 = 1'b1; e_fin.rw_en = 1'b1; e_fin.rw_val = rv_reg;
                end
                default: ;
            endcase
        end

        e_mok = e_maddr <= TOP;
        e_fin.fault = (use1 && b1) || (use2 && b2) ||
                      ((mreq.wr || e_need_mem) && !e_mok);
        mreq.addr = e_maddr;
        mreq.wr   = mreq.wr && e_mok && fin_e;
        mreq.rd   = e_need_mem && e_mok && adv_em;
    end

    // Memory stage: loaded word goes to a register or to the pc.
    assign ld_data = m_ok_reg ? mrdata : 32'd0;

    always_comb
    begin
        m_fin = '0;
        m_fin.npc    = m_to_pc_reg ? ld_data : m_npc_reg;
        m_fin.fault  = m_fault_reg;
        m_fin.rw_en  = m_rw_en_reg;
        m_fin.rw_idx = m_rw_idx_reg;
        m_fin.rw_val = ld_data;
        m_fin.sp_en  = m_to_pc_reg || (m_rw_en_reg && op_reg == OP_POP);
        // A pop into the stack pointer leaves the loaded word plus four.
        m_fin.sp_val = (op_reg == OP_POP && m_rw_idx_reg == 5'(SP_REG)) ?
                       ld_data + 32'd4 : m_sp_reg;
    end

    assign fin   = stage_m_reg ? m_fin : e_fin;
    assign rf_we = fin_fire && fin.rw_en && fin.rw_idx < 5'(REG_COUNT) &&
                   fin.rw_idx != 5'(SP_REG) && fin.rw_idx != 5'(FLAG_REG);

    assign ra1 = instr.instr_word[26:22];
    assign ra2 = instr.instr_word[21:17];

    always_comb
    begin
        q1_next = 32'd0;
        q2_next = 32'd0;
        if (rf_we && fin.rw_idx == ra1)
        begin
            q1_next = fin.rw_val;
        end
        else if (ra1 < 5'(REG_COUNT) && rf_vld_reg[ra1])
        begin
            q1_next = rf_mem[ra1];
        end
        if (rf_we && fin.rw_idx == ra2)
        begin
            q2_next = fin.rw_val;
        end
        else if (ra2 < 5'(REG_COUNT) && rf_vld_reg[ra2])
        begin
            q2_next = rf_mem[ra2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[fin.rw_idx] <= fin.rw_val;
        end
        if (accept)
        begin
            q1_reg  <= q1_next;
            q2_reg  <= q2_next;
            op_reg  <= instr.instr_word[31:27];
            r1_reg  <= ra1;
            r2_reg  <= ra2;
            imm_reg <= {{16{instr.instr_word[15]}}, instr.instr_word[15:0]};
            rv_reg  <= instr.read_value;
        end
        if (adv_em)
        begin
            m_to_pc_reg  <= e_ld_pc;
            m_ok_reg     <= e_mok;
            m_rw_en_reg  <= e_fin.rw_en;
            m_rw_idx_reg <= e_fin.rw_idx;
            m_fault_reg  <= e_fin.fault;
            m_npc_reg    <= e_fin.npc;
            m_sp_reg     <= e_fin.sp_val;
        end
        if (fin_fire)
        begin
            out_npc_reg   <= fin.npc;
            out_pv_reg    <= fin.pv;
            out_pval_reg  <= fin.pval;
            out_hl_reg    <= fin.hl;
            out_fault_reg <= fin.fault;
            out_done_reg  <= fin.npc == {14'd0, prog_words_reg, 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_words_reg <= '0;
            pc_reg         <= '0;
            sp_reg         <= SB;
            flags_reg      <= '0;
            halt_reg       <= 1'b0;
            rf_vld_reg     <= '0;
            stage_e_reg    <= 1'b0;
            stage_m_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                prog_words_reg <= cfg.program_words;
            end
            stage_e_reg <= accept || (stage_e_reg && !fin_e && !adv_em);
            stage_m_reg <= adv_em || (stage_m_reg && !fin_m);
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fin_fire && !halt_reg)
            begin
                pc_reg <= fin.npc;
                if (fin.halt_set)
                begin
                    halt_reg <= 1'b1;
                end
                if (rf_we)
                begin
                    rf_vld_reg[fin.rw_idx] <= 1'b1;
                end
                if (fin.fl_en || (fin.rw_en && fin.rw_idx == 5'(FLAG_REG)))
                begin
                    flags_reg <= fin.fl_en ? fin.fl_val : fin.rw_val;
                end
                // The stack pointer update wins over a pop into the stack pointer.
                if (fin.sp_en)
                begin
                    sp_reg <= fin.sp_val;
                end
                else if (fin.rw_en && fin.rw_idx == 5'(SP_REG))
                begin
                    sp_reg <= fin.rw_val;
                end
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_npc_reg;
    assign result.print_valid = out_pv_reg;
    assign result.print_value = out_pval_reg;
    assign result.halted      = out_hl_reg;
    assign result.done_res    = out_done_reg;
    assign result.fault       = out_fault_reg;

endmodule
